FILE: hdl/ils_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types for the integer list sorter: element word, cell controls,
// control state.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;       // insert the broadcast element
    logic shift_dn;  // each cell takes its upper neighbor
    logic shift_up;  // each cell takes its lower neighbor
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_UNLOAD
  } ils_state_e;

endpackage
`default_nettype wire

FILE: hdl/ils_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_in_if / ils_out_if
// Valid/ready stream channels for list elements and sorted results.
// ----------------------------------------------------------------------------
interface ils_in_if;
  logic            valid;
  logic            ready;
  ils_pkg::value_t value;
  logic            is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface ils_out_if;
  logic            valid;
  logic            ready;
  ils_pkg::value_t sorted_value;
  logic            last_out;
  logic            overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/ils_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_cell
// One slot of the insertion chain: holds one element, compares it with the
// broadcast element and takes new, neighbor or own value.
// ----------------------------------------------------------------------------
module ils_cell (
  input  wire                 clk_i,
  input  ils_pkg::cell_ctrl_t ctrl_i,
  input  ils_pkg::value_t     new_i,
  input  wire                 occ_i,
  input  wire                 prev_disp_i,
  input  ils_pkg::value_t     left_i,
  input  ils_pkg::value_t     right_i,
  output ils_pkg::value_t     value_o,
  output logic                disp_o
);
  import ils_pkg::*;

  value_t value_q, value_d;

  // empty slot or larger element: this slot moves up on insert
  assign disp_o = !occ_i || (value_q > new_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (disp_o) begin
        value_d = prev_disp_i ? left_i : new_i;
      end
    end else if (ctrl_i.shift_dn) begin
      value_d = right_i;
    end else if (ctrl_i.shift_up) begin
      value_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

FILE: hdl/ils_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_chain
// Row of DEPTH cells kept in ascending order, lowest in cell 0.
// Occupancy follows from the element count.
// ----------------------------------------------------------------------------
module ils_chain #(
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire                 clk_i,
  input  ils_pkg::cell_ctrl_t ctrl_i,
  input  wire [CNT_W-1:0]     count_i,
  input  ils_pkg::value_t     new_i,
  output ils_pkg::value_t     head_o,
  output ils_pkg::value_t     tail_o
);
  import ils_pkg::*;

  value_t     val  [DEPTH];
  logic       disp [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t left, right;
    logic   prev_disp;
    logic   occ;

    assign left      = (i == 0) ? val[i] : val[(i == 0) ? 0 : i - 1];
    assign right     = (i == DEPTH - 1) ? val[i] : val[(i == DEPTH - 1) ? i : i + 1];
    assign prev_disp = (i == 0) ? 1'b0 : disp[(i == 0) ? 0 : i - 1];
    assign occ       = count_i > CNT_W'(i);

    ils_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .new_i       (new_i),
      .occ_i       (occ),
      .prev_disp_i (prev_disp),
      .left_i      (left),
      .right_i     (right),
      .value_o     (val[i]),
      .disp_o      (disp[i])
    );
  end

  assign head_o = val[0];
  assign tail_o = val[DEPTH-1];

endmodule
`default_nettype wire

FILE: hdl/integer_list_sorter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_list_sorter_top
// Collects a list of signed 32-bit elements and returns it sorted.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one element per beat; is_last closes the list.
//   out_o  : the sorted list, one element per beat, last_out on the final
//            beat, overflow on every beat of a list that lost elements.
//   ascending_we_i/ascending_i : order select, 1 = smallest first (reset 1).
//            The value in force when the closing beat is taken is used.
// Throughput: while loading, one beat per cycle. Every cell compares its
//   element with the incoming one in the same cycle and the chain opens a
//   gap by one-slot shifts, so insertion never stalls the input.
// Unload: in_i.ready is low while the run drains. The chain shifts one slot
//   per cycle into the output register while the output is not stalled;
//   ascending drains from cell 0, descending drains from the top end and
//   moves the empty slots out first. The closing beat moves control into
//   UNLOAD, which loads the first result into the output register.
// Elements past DEPTH are dropped and flagged. A stalled receiver freezes
//   the chain; the output register holds its beat. The closing result can
//   wait in the output register while the next list already loads.
// Reset clears count, flags and control; element slots are not cleared.
// ----------------------------------------------------------------------------
module integer_list_sorter_top #(
  parameter int unsigned DEPTH = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              ascending_we_i,
  input  wire              ascending_i,
  ils_in_if.sink           in_i,
  ils_out_if.source        out_o
);
  import ils_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ils_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;   // elements held while loading
  logic [CNT_W-1:0] rem_q, rem_d;       // results still to emit
  logic [CNT_W-1:0] skip_q, skip_d;     // empty top slots to flush (descending)
  logic             drop_q, drop_d;
  logic             asc_q;              // config register
  logic             dir_q, dir_d;       // order latched for the run
  logic             ovf_q, ovf_d;       // overflow latched for the run

  logic             out_valid_q, out_valid_d;
  value_t           out_value_q, out_value_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;

  cell_ctrl_t       ctrl;
  value_t           head, tail;
  logic             accept, room, store, pop_en;

  assign room   = count_q != CNT_W'(DEPTH);
  assign accept = in_i.valid && in_i.ready;
  assign store  = accept && room;

  ils_chain #(.DEPTH(DEPTH)) u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .count_i (count_q),
    .new_i   (in_i.value),
    .head_o  (head),
    .tail_o  (tail)
  );

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    skip_d      = skip_q;
    drop_d      = drop_q;
    dir_d       = dir_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    ctrl        = '0;
    in_i.ready  = 1'b0;
    pop_en      = !out_valid_q || out_o.ready;

    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        ctrl.ins   = store;
        if (accept) begin
          if (in_i.is_last) begin
            state_d = ST_UNLOAD;
            rem_d   = count_q + CNT_W'(store);
            skip_d  = asc_q ? '0 : CNT_W'(DEPTH) - (count_q + CNT_W'(store));
            dir_d   = asc_q;
            ovf_d   = drop_q || !room;
            count_d = '0;
            drop_d  = 1'b0;
          end else begin
            count_d = count_q + CNT_W'(store);
            drop_d  = drop_q || !room;
          end
        end
      end
      ST_UNLOAD: begin
        if (pop_en) begin
          ctrl.shift_dn = dir_q;
          ctrl.shift_up = !dir_q;
          if (skip_q != '0) begin
            skip_d = skip_q - CNT_W'(1);
          end else begin
            out_valid_d = 1'b1;
            out_value_d = dir_q ? head : tail;
            out_last_d  = rem_q == CNT_W'(1);
            out_ovf_d   = ovf_q;
            rem_d       = rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              state_d = ST_LOAD;
            end
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      rem_q       <= '0;
      skip_q      <= '0;
      drop_q      <= 1'b0;
      asc_q       <= 1'b1;
      dir_q       <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      skip_q      <= skip_d;
      drop_q      <= drop_d;
      dir_q       <= dir_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (ascending_we_i) begin
        asc_q <= ascending_i;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.overflow     = out_ovf_q;

  // the element count never passes the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count above DEPTH");

  // a closing beat always starts a drain with at least one result
  a_last_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.is_last |=> state_q == ST_UNLOAD && rem_q != '0)
    else $error("closing beat did not start a run");

  // while draining there is always something left and input is held off
  a_unload_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UNLOAD |-> rem_q != '0 && !in_i.ready)
    else $error("drain state with nothing left or input open");

  // the final result of a run hands control back to loading
  a_last_beat_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d && !out_valid_q && out_last_d |-> state_d == ST_LOAD)
    else $error("final result without return to load");

endmodule
`default_nettype wire

FILE: tb/sorted_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_run_checker
// Watches the element and sorted channels. It rebuilds each list as it is
// accepted, sorts it in the order in force at the closing beat, and compares
// every sorted beat with the oldest waiting expectation.
// ----------------------------------------------------------------------------
module sorted_run_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         ascending_we_i,
  input  wire         ascending_i,
  ils_in_if           elem_i,
  ils_out_if          sorted_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_beats_o
);
  import ils_pkg::*;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_beat_t;

  value_t       list_q[$];
  sorted_beat_t expected_q[$];
  logic         list_dropped;
  logic         order_up;
  int unsigned  mismatches;

  function automatic logic goes_after(value_t a, value_t b, logic up);
    return up ? (a > b) : (a < b);
  endfunction

  // insertion sort of the collected list, in place
  function automatic void sort_list(logic up);
    value_t held;
    int     slot;
    for (int i = 1; i < list_q.size(); i++) begin
      held = list_q[i];
      slot = i;
      while (slot > 0 && goes_after(list_q[slot-1], held, up)) begin
        list_q[slot] = list_q[slot-1];
        slot--;
      end
      list_q[slot] = held;
    end
  endfunction

  function automatic void close_list();
    sorted_beat_t b;
    sort_list(order_up);
    foreach (list_q[k]) begin
      b.value = list_q[k];
      b.last  = (k == list_q.size() - 1);
      b.ovf   = list_dropped;
      expected_q.push_back(b);
    end
    list_q.delete();
    list_dropped = 1'b0;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sorted_beat_t got_b;
    sorted_beat_t exp_b;
    if (!rst_ni) begin
      list_q.delete();
      expected_q.delete();
      list_dropped     = 1'b0;
      order_up         = 1'b1;
      mismatches       = 0;
      mismatch_count_o <= 0;
      pending_beats_o  <= 0;
    end else begin
      // output side first: a beat never answers a list closed at this edge
      if (sorted_i.valid && sorted_i.ready) begin
        got_b.value = sorted_i.sorted_value;
        got_b.last  = sorted_i.last_out;
        got_b.ovf   = sorted_i.overflow;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected sorted beat: value %0d last %0b overflow %0b",
                                 got_b.value, got_b.last, got_b.ovf));
        end else begin
          exp_b = expected_q.pop_front();
          if (got_b !== exp_b) begin
            note_failure($sformatf(
              "sorted beat mismatch: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
              exp_b.value, exp_b.last, exp_b.ovf, got_b.value, got_b.last, got_b.ovf));
          end
        end
      end
      if (elem_i.valid && elem_i.ready) begin
        if (list_q.size() < DEPTH) list_q.push_back(elem_i.value);
        else list_dropped = 1'b1;
        if (elem_i.is_last) close_list();
      end
      // a write takes effect after this edge
      if (ascending_we_i) order_up = ascending_i;
      mismatch_count_o <= mismatches;
      pending_beats_o  <= expected_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lists of signed elements into the integer list sorter and lets a
// checker compare every sorted beat; prints the verdict at the end.
// ----------------------------------------------------------------------------
module testbench;
  import ils_pkg::*;

  localparam int unsigned DEPTH = 64;
  // long receiver hold-off used to back the sorter up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  // quiet margin after the last predicted beat, before a register write
  localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
  // cycles without any beat on either channel before the run is abandoned;
  // worst legal stretch is the hold-off plus a full descending drain
  localparam int unsigned IDLE_LIMIT = 3000;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  logic asc_we;
  logic asc_val;

  ils_in_if  elem_if ();
  ils_out_if sorted_if ();

  int unsigned mismatch_count;
  int unsigned pending_beats;
  int unsigned idle_cycles;

  // hold-off handshake between stimulus and receiver: one writer each
  int unsigned hold_requests;
  int unsigned holds_served;

  bit          sender_gaps_on;
  bit          receiver_stalls_on;
  int unsigned burst_left;

  integer_list_sorter_top #(.DEPTH(DEPTH)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .ascending_we_i (asc_we),
    .ascending_i    (asc_val),
    .in_i           (elem_if),
    .out_o          (sorted_if)
  );

  sorted_run_checker #(.DEPTH(DEPTH)) sort_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .ascending_we_i   (asc_we),
    .ascending_i      (asc_val),
    .elem_i           (elem_if),
    .sorted_i         (sorted_if),
    .mismatch_count_o (mismatch_count),
    .pending_beats_o  (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: either always ready, or alternating ready/stall runs of random
  // length. A hold-off request from the stimulus drops ready for a long,
  // fixed stretch so the chain backs up and in_i.ready goes low.
  // --------------------------------------------------------------------------
  initial begin : receiver
    logic        rdy_level;
    int unsigned run_left;
    rdy_level = 1'b1;
    run_left  = 0;
    sorted_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        sorted_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!receiver_stalls_on) begin
        sorted_if.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rdy_level = !rdy_level;
          run_left  = rdy_level ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        run_left--;
        sorted_if.ready <= rdy_level;
      end
    end
  end

  // Watchdog: only counts cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((elem_if.valid && elem_if.ready) || (sorted_if.valid && sorted_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("integer_list_sorter_top verification failed");
        $finish;
      end
    end
  end

  // Order register write; only called while the sorter is idle.
  task automatic write_order(input logic up);
    asc_we  <= 1'b1;
    asc_val <= up;
    @(posedge clk);
    asc_we  <= 1'b0;
  endtask

  // Offer one element and wait for it to be taken. With gaps enabled the
  // sender works in bursts; valid only drops at the start of a gap, so a
  // continuing burst keeps valid high from beat to beat.
  task automatic offer_elem(input value_t v, input logic last);
    int unsigned gap;
    if (sender_gaps_on && burst_left == 0) begin
      elem_if.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    elem_if.valid   <= 1'b1;
    elem_if.value   <= v;
    elem_if.is_last <= last;
    @(posedge clk);
    while (!elem_if.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // Mix of full-range words, a narrow band (many duplicates) and extremes.
  function automatic value_t random_elem();
    value_t v;
    case ($urandom_range(0, 3))
      0: v = value_t'(int'($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = value_t'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_list(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) offer_elem(random_elem(), i == len - 1);
  endtask

  // Stop offering, wait for every predicted beat, then let the chain settle.
  // Apart from the first one after reset, register writes only ever follow this.
  task automatic drain_and_settle();
    elem_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending_beats == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    int unsigned sent;
    rst_n           <= 1'b0;
    asc_we          <= 1'b0;
    asc_val         <= 1'b1;
    elem_if.valid   <= 1'b0;
    elem_if.value   <= '0;
    elem_if.is_last <= 1'b0;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    burst_left         = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-element list at the negative extreme
    write_order(1'b1);
    offer_elem(VAL_MIN, 1'b1);

    // both extremes, zero, +/-1 and a duplicate pair, in each order
    for (int r = 0; r < 2; r++) begin
      if (r == 1) begin
        drain_and_settle();
        write_order(1'b0);
      end
      offer_elem(VAL_MAX, 1'b0);
      offer_elem(VAL_MIN, 1'b0);
      offer_elem(32'sd0, 1'b0);
      offer_elem(-32'sd1, 1'b0);
      offer_elem(32'sd1, 1'b0);
      offer_elem(32'sd5, 1'b0);
      offer_elem(32'sd5, 1'b1);
    end

    // descending single element: the chain drains all empty slots first
    offer_elem(VAL_MAX, 1'b1);
    // alternating bit patterns, every bit of value in both states
    offer_elem(32'shaaaa_aaaa, 1'b0);
    offer_elem(32'sh5555_5555, 1'b1);

    // random phases, mostly short lists, first phase without any idling
    for (int phase = 0; phase < 3; phase++) begin
      drain_and_settle();
      write_order(logic'($urandom_range(0, 1)));
      sender_gaps_on     = (phase != 0) && ($urandom_range(0, 4) != 0);
      receiver_stalls_on = (phase != 0) && ($urandom_range(0, 4) != 0);
      sent = 0;
      while (sent < 6) begin
        n = $urandom_range(1, 10);
        send_list(n);
        sent += n;
      end
    end

    // capacity: an overfull list descending, the store fills exactly and
    // the closing element (and two before it) gets dropped
    drain_and_settle();
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    write_order(1'b0);
    send_list(DEPTH + 3);

    // back-pressure: receiver holds off while the sender keeps offering a
    // second list, so the sorter stalls its input during the unload
    drain_and_settle();
    write_order(1'b1);
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_requests++;
    send_list(3);
    send_list(12);

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("integer_list_sorter_top verification clean");
    end else begin
      $display("integer_list_sorter_top verification failed");
    end
    $finish;
  end

endmodule

FILE: integer_list_sorter_top.f
hdl/ils_pkg.sv
hdl/ils_if.sv
hdl/ils_cell.sv
hdl/ils_chain.sv
hdl/integer_list_sorter_top.sv
tb/sorted_run_checker.sv
tb/testbench.sv
